// ===== rtl/modular_exponentiation_macros.svh =====
// ----------------------------------------------------------------------------
// modular exponentiation assertion macros
// concurrent checks clocked by clk and disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_MACROS_SVH
`define MODULAR_EXPONENTIATION_MACROS_SVH
`ifndef SYNTH
// implication checked on every clock edge out of reset
`define MODEXP_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("modexp assertion failed");
// condition that must never hold
`define MODEXP_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("modexp forbidden condition");
`else
`define MODEXP_ASSERT(lbl, prop)
`define MODEXP_NEVER(lbl, cond)
`endif
`endif

// ===== rtl/modexp_pkg.sv =====
// ----------------------------------------------------------------------------
// modexp_pkg
// shared constants and types of the modular exponentiation block
// ----------------------------------------------------------------------------
package modexp_pkg;
	localparam int DEFAULT_WORD_BITS = 64;
	localparam int FIELD_BITS = 64;

	// status of the bit-serial modular multiplier
	typedef struct packed {
		logic busy;
		logic done;
	} modexp_mul_status_t;
endpackage

// ===== rtl/modexp_cell.sv =====
// ----------------------------------------------------------------------------
// modexp_cell
// one bit of the multiplier operand chain: loads in parallel, then shifts
// ----------------------------------------------------------------------------
module modexp_cell
	import modexp_pkg::*;
(
	input  logic clk,
	input  logic load,
	input  logic shift,
	input  logic load_bit,
	input  logic neighbor_bit,
	output logic bit_q
);
	always_ff @(posedge clk) begin
		if (load) begin
			bit_q <= load_bit;
		end else if (shift) begin
			bit_q <= neighbor_bit;
		end
	end
endmodule

// ===== rtl/modexp_mulmod.sv =====
// ----------------------------------------------------------------------------
// modexp_mulmod
// bit-serial (a * b) mod m, msb first, one operand bit per cycle
// ----------------------------------------------------------------------------
module modexp_mulmod
	import modexp_pkg::*;
#(
	parameter int WORD_BITS = DEFAULT_WORD_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [WORD_BITS-1:0] op_a,
	input  logic [WORD_BITS-1:0] op_b,
	input  logic [WORD_BITS-1:0] op_m,
	output logic [WORD_BITS-1:0] product,
	output modexp_mul_status_t   status
);
	localparam int CNT_BITS = $clog2(WORD_BITS + 1);

	logic [WORD_BITS-1:0] a_q;
	logic [WORD_BITS-1:0] acc_q;
	logic [CNT_BITS-1:0]  cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [WORD_BITS-1:0] chain;
	logic [WORD_BITS:0]   dbl_sum;
	logic [WORD_BITS-1:0] dbl;
	logic [WORD_BITS:0]   add_sum;
	logic [WORD_BITS-1:0] acc_next;

	// chain of operand cells, lsb cell takes a zero
	for (genvar i = 0; i < WORD_BITS; i++) begin : g_cell
		logic nb;
		if (i == 0) begin : g_lsb
			assign nb = 1'b0;
		end else begin : g_mid
			assign nb = chain[i-1];
		end
		modexp_cell u_cell (
			.clk          (clk),
			.load         (start),
			.shift        (busy_q),
			.load_bit     (op_b[i]),
			.neighbor_bit (nb),
			.bit_q        (chain[i])
		);
	end

	// double then conditionally add, each reduced by one subtract
	always_comb begin
		dbl_sum = {1'b0, acc_q} + {1'b0, acc_q};
		if (dbl_sum >= {1'b0, op_m}) begin
			dbl = WORD_BITS'(dbl_sum - {1'b0, op_m});
		end else begin
			dbl = dbl_sum[WORD_BITS-1:0];
		end
		add_sum = {1'b0, dbl} + {1'b0, a_q};
		if (!chain[WORD_BITS-1]) begin
			acc_next = dbl;
		end else if (add_sum >= {1'b0, op_m}) begin
			acc_next = WORD_BITS'(add_sum - {1'b0, op_m});
		end else begin
			acc_next = add_sum[WORD_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_BITS'(WORD_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= op_a;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_next;
		end
	end

	assign product     = acc_q;
	assign status.busy = busy_q;
	assign status.done = done_q;
endmodule

// ===== rtl/modular_exponentiation.sv =====
// ----------------------------------------------------------------------------
// modular_exponentiation
// base^exponent mod modulus by right-to-left binary square-and-multiply
// ----------------------------------------------------------------------------
// channel | direction | handshake          | payload
// input   | in        | in_valid, in_stall | base, exponent, modulus
// output  | out       | out_valid, out_stall | result, bad_modulus
//
// one transaction at a time; each modular multiply waits on the bit-serial
// multiplier and is followed by a step or shift state
// a transaction costs up to (2*WORD_BITS) multiplies
// zero modulus or zero exponent go from idle straight to the finish state
// reset clears control only; in_stall stays high while a transaction is busy
// the finished result waits in the output register while out_stall is high
// ----------------------------------------------------------------------------
`include "modular_exponentiation_macros.svh"

module modular_exponentiation
	import modexp_pkg::*;
#(
	parameter int WORD_BITS = DEFAULT_WORD_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [FIELD_BITS-1:0] base,
	input  logic [FIELD_BITS-1:0] exponent,
	input  logic [FIELD_BITS-1:0] modulus,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [FIELD_BITS-1:0] result,
	output logic                  bad_modulus
);
	typedef enum logic [2:0] {
		ST_IDLE, ST_RED, ST_STEP, ST_MACC, ST_SHIFT, ST_MSQ, ST_FINISH
	} state_t;

	state_t               state_q;
	logic [WORD_BITS-1:0] exp_q;
	logic [WORD_BITS-1:0] mod_q;
	logic [WORD_BITS-1:0] sq_q;
	logic [WORD_BITS-1:0] acc_q;
	logic [WORD_BITS-1:0] res_q;
	logic                 bad_q;
	logic                 mul_start_q;
	logic [WORD_BITS-1:0] mul_a_q;
	logic [WORD_BITS-1:0] mul_b_q;
	logic                 out_valid_q;
	logic [WORD_BITS-1:0] out_res_q;
	logic                 out_bad_q;
	logic [WORD_BITS-1:0] mul_p;
	modexp_mul_status_t   mul_st;
	logic                 mul_go;

	// only the low WORD_BITS of each field take part
	logic [WORD_BITS-1:0] base_w;
	logic [WORD_BITS-1:0] exp_w;
	logic [WORD_BITS-1:0] mod_w;
	assign base_w = base[WORD_BITS-1:0];
	assign exp_w  = exponent[WORD_BITS-1:0];
	assign mod_w  = modulus[WORD_BITS-1:0];

	modexp_mulmod #(.WORD_BITS(WORD_BITS)) u_mulmod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start_q),
		.op_a    (mul_a_q),
		.op_b    (mul_b_q),
		.op_m    (mod_q),
		.product (mul_p),
		.status  (mul_st)
	);

	// states that launch a multiply on the next cycle
	always_comb begin
		case (state_q)
			ST_IDLE:  mul_go = in_valid && (mod_w != '0) && (exp_w != '0);
			ST_STEP:  mul_go = exp_q[0];
			ST_SHIFT: mul_go = ((exp_q >> 1) != '0);
			default:  mul_go = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mul_start_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			mul_start_q <= mul_go;
			// drain the output register unless a new result refills it
			if (out_valid_q && !out_stall && state_q != ST_FINISH) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						exp_q <= exp_w;
						mod_q <= mod_w;
						bad_q <= (mod_w == '0);
						// a modulus of one leaves the running product at zero
						acc_q <= (mod_w == WORD_BITS'(1)) ? '0 : WORD_BITS'(1);
						if (mod_w == '0) begin
							res_q   <= '0;
							state_q <= ST_FINISH;
						end else if (exp_w == '0) begin
							res_q   <= WORD_BITS'(1);
							state_q <= ST_FINISH;
						end else begin
							// base mod modulus as 1 * base through the multiplier
							mul_a_q <= WORD_BITS'(1);
							mul_b_q <= base_w;
							state_q <= ST_RED;
						end
					end
				end
				ST_RED: begin
					if (mul_st.done) begin
						sq_q    <= mul_p;
						state_q <= ST_STEP;
					end
				end
				ST_STEP: begin
					if (exp_q[0]) begin
						mul_a_q <= acc_q;
						mul_b_q <= sq_q;
						state_q <= ST_MACC;
					end else begin
						state_q <= ST_SHIFT;
					end
				end
				ST_MACC: begin
					if (mul_st.done) begin
						acc_q   <= mul_p;
						state_q <= ST_SHIFT;
					end
				end
				ST_SHIFT: begin
					exp_q <= exp_q >> 1;
					if ((exp_q >> 1) != '0) begin
						mul_a_q <= sq_q;
						mul_b_q <= sq_q;
						state_q <= ST_MSQ;
					end else begin
						res_q   <= acc_q;
						state_q <= ST_FINISH;
					end
				end
				ST_MSQ: begin
					if (mul_st.done) begin
						sq_q    <= mul_p;
						state_q <= ST_STEP;
					end
				end
				ST_FINISH: begin
					// hand over once the output register is free or draining
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						out_res_q   <= res_q;
						out_bad_q   <= bad_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_stall    = (state_q != ST_IDLE);
	assign out_valid   = out_valid_q;
	assign result      = FIELD_BITS'(out_res_q);
	assign bad_modulus = out_bad_q;

	// one transaction in flight: an accepted input closes the input side
	`MODEXP_ASSERT(a_accept_closes, (in_valid && !in_stall) |=> in_stall)
	// an error result always carries a zero value
	`MODEXP_ASSERT(a_bad_zero, (out_valid && bad_modulus) |-> (result == '0))
	// the multiplier is never restarted while it is still working
	`MODEXP_NEVER(a_no_restart, mul_start_q && mul_st.busy)
endmodule
